[src/xrs_pkg.sv]
`timescale 1ns / 1ps

package xrs_pkg;

	localparam logic [63:0] SEED_FALLBACK = 64'h1234567890abcdef;
	localparam int SHL_A = 13;
	localparam int SHR_B = 7;
	localparam int SHL_C = 17;
	localparam int FRAC_SHIFT = 11;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS = 64;
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [3:0] UUID_VERSION = 4'h4;
	localparam logic [1:0] UUID_VARIANT = 2'b10;

	typedef enum logic [2:0] {
		REQ_INT63  = 3'd0,
		REQ_RANGE  = 3'd1,
		REQ_FRAC53 = 3'd2,
		REQ_BOOL   = 3'd3,
		REQ_UUID   = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		OP_INT63,
		OP_FRAC53,
		OP_BOOL,
		OP_UUID,
		OP_LOW,
		OP_FULL,
		OP_MOD
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] low;
		logic [63:0] span;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_RES,
		B_UUID2
	} bst_t;

	function automatic logic [63:0] xs_next(input logic [63:0] s);
		logic [63:0] x;
		x = s ^ (s << SHL_A);
		x = x ^ (x >> SHR_B);
		x = x ^ (x << SHL_C);
		return x;
	endfunction

	function automatic logic [63:0] uuid_hi(input logic [63:0] x);
		return {x[63:56], UUID_VERSION, x[51:0]};
	endfunction

	function automatic logic [63:0] uuid_lo(input logic [63:0] x);
		return {x[63:8], UUID_VARIANT, x[5:0]};
	endfunction

endpackage

[src/xrs_front.sv]
`timescale 1ns / 1ps

module xrs_front import xrs_pkg::*; (
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [63:0] range_low,
	input  logic [63:0] range_high,
	input  logic        q_ready,
	output logic        push,
	output cmd_t        cmd
);

	logic        known;
	logic        low_ge_high;
	logic [63:0] span;

	assign low_ge_high = $signed(range_low) >= $signed(range_high);
	assign span = range_high - range_low + 64'd1;

	always_comb begin
		known = 1'b1;
		cmd.low = range_low;
		cmd.span = span;
		cmd.op = OP_INT63;
		unique case (req_type)
			REQ_INT63: cmd.op = OP_INT63;
			REQ_FRAC53: cmd.op = OP_FRAC53;
			REQ_BOOL: cmd.op = OP_BOOL;
			REQ_UUID: cmd.op = OP_UUID;
			REQ_RANGE: begin
				if (low_ge_high) begin
					cmd.op = OP_LOW;
				end else if (span == 64'd0) begin
					cmd.op = OP_FULL;
				end else begin
					cmd.op = OP_MOD;
				end
			end
			default: known = 1'b0;
		endcase
	end

	// drop unknown request types
	assign req_stall = !q_ready;
	assign push = req_valid && q_ready && known;

endmodule

[src/xrs_queue.sv]
`timescale 1ns / 1ps

module xrs_queue import xrs_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic ready,
	input  logic pop,
	output logic valid,
	output cmd_t dout
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign ready = count_q != CntW'(Depth);
	assign valid = count_q != '0;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

[src/xrs_back.sv]
`timescale 1ns / 1ps

module xrs_back import xrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] seed_value,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] value,
	output logic        last
);

	bst_t             state_q, state_d;
	logic [63:0]      gen_q, gen_d;
	logic [63:0]      next;
	logic [63:0]      rem_q, rem_d;
	logic [63:0]      dvd_q, dvd_d;
	logic [63:0]      span_q, span_d;
	logic [63:0]      low_q, low_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [64:0]      trial;
	logic             out_valid_q, out_valid_d;
	logic [63:0]      value_q, value_d;
	logic             last_q, last_d;
	logic             out_free;
	logic             load;

	assign cfg_ready = 1'b1;
	assign next = xs_next(gen_q);
	assign out_free = !out_valid_q || !rsp_stall;
	assign trial = {rem_q, dvd_q[63]};

	always_comb begin
		state_d = state_q;
		gen_d = gen_q;
		rem_d = rem_q;
		dvd_d = dvd_q;
		span_d = span_q;
		low_d = low_q;
		cnt_d = cnt_q;
		value_d = value_q;
		last_d = last_q;
		load = 1'b0;
		pop = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid && out_free) begin
					pop = 1'b1;
					last_d = 1'b1;
					unique case (q_cmd.op)
						OP_INT63: begin
							gen_d = next;
							load = 1'b1;
							value_d = next >> 1;
						end
						OP_FRAC53: begin
							gen_d = next;
							load = 1'b1;
							value_d = next >> FRAC_SHIFT;
						end
						OP_BOOL: begin
							gen_d = next;
							load = 1'b1;
							value_d = {63'd0, next[0]};
						end
						OP_UUID: begin
							gen_d = next;
							load = 1'b1;
							value_d = uuid_hi(next);
							last_d = 1'b0;
							state_d = B_UUID2;
						end
						OP_LOW: begin
							load = 1'b1;
							value_d = q_cmd.low;
						end
						OP_FULL: begin
							gen_d = next;
							load = 1'b1;
							value_d = q_cmd.low + next;
						end
						OP_MOD: begin
							gen_d = next;
							dvd_d = next;
							rem_d = '0;
							span_d = q_cmd.span;
							low_d = q_cmd.low;
							cnt_d = '0;
							state_d = B_DIV;
						end
						default: pop = 1'b1;
					endcase
				end
			end
			B_DIV: begin
				if (trial >= {1'b0, span_q}) begin
					rem_d = 64'(trial - {1'b0, span_q});
				end else begin
					rem_d = trial[63:0];
				end
				dvd_d = {dvd_q[62:0], 1'b0};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == '1) begin
					state_d = B_RES;
				end
			end
			B_RES: begin
				if (out_free) begin
					load = 1'b1;
					value_d = low_q + rem_q;
					last_d = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_UUID2: begin
				if (out_free) begin
					gen_d = next;
					load = 1'b1;
					value_d = uuid_lo(next);
					last_d = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
		if (cfg_valid) begin
			gen_d = (seed_value == 64'd0) ? SEED_FALLBACK : seed_value;
		end
		out_valid_d = load || (out_valid_q && rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			gen_q <= SEED_FALLBACK;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			gen_q <= gen_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		dvd_q <= dvd_d;
		span_q <= span_d;
		low_q <= low_d;
		if (load) begin
			value_q <= value_d;
			last_q <= last_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign value = value_q;
	assign last = last_q;

endmodule

[src/xorshift64_random_source_core.sv]
`timescale 1ns / 1ps
// Channel | handshake            | payload
// --------+----------------------+-------------------------------------
// req     | req_valid, req_stall | req_type, range_low, range_high
// rsp     | rsp_valid, rsp_stall | value, last
// cfg     | cfg_valid, cfg_ready | seed_value
//
// Int63, fraction, bool, empty range and full range: loaded into the output register at the pop.
// Range with a nonzero span: the radix-2 restoring divider reduces the draw modulo the span
// (one quotient bit per cycle over 64 dividend bits), then the low bound is added.
// UUID: two words, one generator step per word.
// Reset loads the generator with 0x1234567890abcdef; no clearing pass.
// A stalled result holds while the queue keeps taking requests until full.

module xorshift64_random_source_core import xrs_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] seed_value,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [63:0] range_low,
	input  logic [63:0] range_high,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] value,
	output logic        last
);

	logic q_ready;
	logic push;
	logic pop;
	logic q_valid;
	cmd_t cmd_in;
	cmd_t cmd_out;

	xrs_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.range_low  (range_low),
		.range_high (range_high),
		.q_ready    (q_ready),
		.push       (push),
		.cmd        (cmd_in)
	);

	xrs_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.ready  (q_ready),
		.pop    (pop),
		.valid  (q_valid),
		.dout   (cmd_out)
	);

	xrs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed_value (seed_value),
		.q_valid    (q_valid),
		.q_cmd      (cmd_out),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.value      (value),
		.last       (last)
	);

endmodule

[src/xrs_checker.sv]
`timescale 1ns / 1ps

module xrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [63:0] value,
	input logic        last
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(value) && $stable(last))
		else $error("stalled result changed");

	// high word of a uuid carries version 4
	a_uuid_version: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> value[55:52] == 4'h4)
		else $error("uuid high word lacks version nibble");

	// low word follows the high word transfer at once
	a_uuid_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !last |=> rsp_valid && last && value[7:6] == 2'b10)
		else $error("uuid low word did not follow");

endmodule

bind xorshift64_random_source_core xrs_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.value     (value),
	.last      (last)
);
